>>> hdl/exp2x_pkg.sv
// ----------------------------------------------------------------------------
// exp2x_pkg
// Shared constants, types and helpers for the e^(2x) Taylor series block.
// ----------------------------------------------------------------------------
package exp2x_pkg;

   // Fixed-point format of the working terms and sums
   localparam int FRAC_BITS = 24;
   localparam int OUT_FRAC  = 24;
   localparam int REF_TERMS = 24;

   // Field widths
   localparam int X_W     = 17;
   localparam int X_FRAC  = 16;
   localparam int CNT_W   = 5;
   localparam int OUT_W   = 28;
   localparam int TWO_X_W = X_W + 1;

   // Datapath widths: a term never exceeds 2.0, a pre-divide value 4.0,
   // a sum stays below 8.0 inside the valid range
   localparam int TERM_W    = FRAC_BITS + 2;
   localparam int PROD_W    = TERM_W + TWO_X_W;
   localparam int DIV_W     = FRAC_BITS + 3;
   localparam int DIV_STEPS = (DIV_W + 3) / 4;
   localparam int DIV_PAD   = 4 * DIV_STEPS;
   localparam int DSTEP_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int SUM_W     = FRAC_BITS + 4;

   // Alignment of the sums to the output format
   localparam int SHR = (FRAC_BITS >= OUT_FRAC) ? (FRAC_BITS - OUT_FRAC) : 0;
   localparam int SHL = (FRAC_BITS >= OUT_FRAC) ? 0 : (OUT_FRAC - FRAC_BITS);

   // Valid argument range, Q1.16
   localparam logic [X_W-1:0] X_MIN = X_W'(6554);
   localparam logic [X_W-1:0] X_MAX = X_W'(65536);

   localparam logic [CNT_W-1:0]  NUM_TERMS_RST = CNT_W'(5);
   localparam logic [CNT_W-1:0]  REF_CNT       = CNT_W'(REF_TERMS);
   localparam logic [TERM_W-1:0] TERM_ONE      = TERM_W'(1) << FRAC_BITS;
   localparam logic [SUM_W-1:0]  SUM_ONE       = SUM_W'(1) << FRAC_BITS;
   localparam logic [DSTEP_W-1:0] DSTEP_LAST   = DSTEP_W'(DIV_STEPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ACC
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic reject;
      logic mul;
      logic div_step;
      logic acc;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic x_in_range;
      logic div_last;
      logic k_last;
   } dp_status_type;

   // Bring a working sum to the Q4.24 output format
   function automatic logic [OUT_W-1:0] to_out(input logic [SUM_W-1:0] sum);
      logic [63:0] wide;
      wide = 64'(sum);
      if (FRAC_BITS >= OUT_FRAC) begin
         wide = wide >> SHR;
      end else begin
         wide = wide << SHL;
      end
      return wide[OUT_W-1:0];
   endfunction

endpackage

>>> hdl/exp2x_ctrl.sv
// ----------------------------------------------------------------------------
// exp2x_ctrl
// Sequencer: walks each in-range request through multiply, divide and
// accumulate for every series term.
// ----------------------------------------------------------------------------
module exp2x_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  exp2x_pkg::dp_status_type status,
   output exp2x_pkg::ctrl_cmd_type  cmd
);

   exp2x_pkg::state_type state_ff;
   exp2x_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= exp2x_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         exp2x_pkg::ST_IDLE: begin
            if (start) begin
               if (status.x_in_range) begin
                  cmd.load = 1'b1;
                  state_in = exp2x_pkg::ST_MUL;
               end else begin
                  cmd.reject = 1'b1;
               end
            end
         end
         exp2x_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = exp2x_pkg::ST_DIV;
         end
         exp2x_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = exp2x_pkg::ST_ACC;
            end
         end
         exp2x_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.k_last) begin
               cmd.finish = 1'b1;
               state_in   = exp2x_pkg::ST_IDLE;
            end else begin
               state_in = exp2x_pkg::ST_MUL;
            end
         end
         default: begin
            state_in = exp2x_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != exp2x_pkg::ST_IDLE);

   // A valid request always enters the multiply step next
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && status.x_in_range |=> state_ff == exp2x_pkg::ST_MUL)
      else $error("valid request did not start the term loop");

   // The divide step always follows a multiply
   assert property (@(posedge clock) disable iff (reset)
      state_ff == exp2x_pkg::ST_MUL |=> state_ff == exp2x_pkg::ST_DIV)
      else $error("multiply not followed by divide");

endmodule

>>> hdl/exp2x_dpath.sv
// ----------------------------------------------------------------------------
// exp2x_dpath
// Term datapath: one multiplier, a radix-16 restoring divider by k and the
// two running sums, plus the term count register and the response register.
// ----------------------------------------------------------------------------
module exp2x_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [exp2x_pkg::X_W-1:0]            req_x_value,
   input  logic                                 csr_wr_en,
   input  logic [exp2x_pkg::CNT_W-1:0]          csr_wr_data,
   input  exp2x_pkg::ctrl_cmd_type               cmd,
   output exp2x_pkg::dp_status_type              status,
   output logic                                 rsp_strobe,
   output logic [exp2x_pkg::OUT_W-1:0]          rsp_series_sum,
   output logic [exp2x_pkg::OUT_W-1:0]          rsp_reference_sum,
   output logic                                 rsp_range_error
);

   logic [exp2x_pkg::CNT_W-1:0]   num_terms_ff;
   logic [exp2x_pkg::TWO_X_W-1:0] two_x_ff;
   logic [exp2x_pkg::TERM_W-1:0]  term_ff;
   logic [exp2x_pkg::CNT_W-1:0]   k_ff;
   logic [exp2x_pkg::CNT_W-1:0]   limit_ff;
   logic [exp2x_pkg::SUM_W-1:0]   series_ff;
   logic [exp2x_pkg::SUM_W-1:0]   ref_ff;
   logic [exp2x_pkg::DIV_PAD-1:0] num_ff;
   logic [exp2x_pkg::CNT_W-1:0]   rem_ff;
   logic [exp2x_pkg::DSTEP_W-1:0] dstep_ff;
   logic                          strobe_ff;
   logic [exp2x_pkg::OUT_W-1:0]   series_out_ff;
   logic [exp2x_pkg::OUT_W-1:0]   ref_out_ff;
   logic                          error_ff;

   logic [exp2x_pkg::PROD_W-1:0]  prod;
   logic [exp2x_pkg::DIV_PAD-1:0] num_in;
   logic [exp2x_pkg::CNT_W-1:0]   rem_in;
   logic [exp2x_pkg::TERM_W-1:0]  term_in;
   logic [exp2x_pkg::SUM_W-1:0]   series_in;
   logic [exp2x_pkg::SUM_W-1:0]   ref_in;
   logic [exp2x_pkg::CNT_W-1:0]   limit_in;

   // Status back to the controller
   assign status.x_in_range = (req_x_value >= exp2x_pkg::X_MIN) &&
                              (req_x_value <= exp2x_pkg::X_MAX);
   assign status.div_last   = (dstep_ff == exp2x_pkg::DSTEP_LAST);
   assign status.k_last     = (k_ff == limit_ff);

   // Term count register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_terms_ff <= exp2x_pkg::NUM_TERMS_RST;
      end else if (csr_wr_en) begin
         num_terms_ff <= csr_wr_data;
      end
   end

   // Run long enough to cover both series
   assign limit_in = (num_terms_ff > exp2x_pkg::REF_CNT) ? num_terms_ff
                                                         : exp2x_pkg::REF_CNT;

   // Term times 2x
   assign prod = exp2x_pkg::PROD_W'(term_ff) * exp2x_pkg::PROD_W'(two_x_ff);

   // Four quotient bits per cycle, divisor k
   always_comb begin
      logic [exp2x_pkg::CNT_W:0] trial;
      num_in = num_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 4; i++) begin
         trial  = {rem_in, num_in[exp2x_pkg::DIV_PAD-1]};
         num_in = {num_in[exp2x_pkg::DIV_PAD-2:0], 1'b0};
         if (trial >= {1'b0, k_ff}) begin
            trial     = trial - {1'b0, k_ff};
            num_in[0] = 1'b1;
         end
         rem_in = trial[exp2x_pkg::CNT_W-1:0];
      end
   end

   // Add the new term to each sum that still includes it
   assign term_in   = exp2x_pkg::TERM_W'(num_ff);
   assign series_in = (k_ff <= num_terms_ff)
                      ? series_ff + exp2x_pkg::SUM_W'(term_in) : series_ff;
   assign ref_in    = (k_ff <= exp2x_pkg::REF_CNT)
                      ? ref_ff + exp2x_pkg::SUM_W'(term_in) : ref_ff;

   // Term loop registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         two_x_ff  <= {req_x_value, 1'b0};
         term_ff   <= exp2x_pkg::TERM_ONE;
         k_ff      <= exp2x_pkg::CNT_W'(1);
         limit_ff  <= limit_in;
         series_ff <= exp2x_pkg::SUM_ONE;
         ref_ff    <= exp2x_pkg::SUM_ONE;
      end
      if (cmd.mul) begin
         num_ff   <= exp2x_pkg::DIV_PAD'(prod >> exp2x_pkg::X_FRAC);
         rem_ff   <= '0;
         dstep_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         dstep_ff <= dstep_ff + exp2x_pkg::DSTEP_W'(1);
      end
      if (cmd.acc) begin
         term_ff   <= term_in;
         series_ff <= series_in;
         ref_ff    <= ref_in;
         k_ff      <= k_ff + exp2x_pkg::CNT_W'(1);
      end
   end

   // Response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish || cmd.reject;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.reject) begin
         series_out_ff <= '0;
         ref_out_ff    <= '0;
         error_ff      <= 1'b1;
      end else if (cmd.finish) begin
         series_out_ff <= exp2x_pkg::to_out(series_in);
         ref_out_ff    <= exp2x_pkg::to_out(ref_in);
         error_ff      <= 1'b0;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_series_sum    = series_out_ff;
   assign rsp_reference_sum = ref_out_ff;
   assign rsp_range_error   = error_ff;

   // A rejected argument gives zero sums
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff && error_ff |-> series_out_ff == '0 && ref_out_ff == '0)
      else $error("range error response with non-zero sums");

   // Remainder always below the divisor, and the divisor never zero
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> k_ff != '0 && rem_ff < k_ff)
      else $error("divider remainder out of range");

   // The term index never passes the loop limit
   assert property (@(posedge clock) disable iff (reset)
      cmd.acc |-> k_ff <= limit_ff)
      else $error("term index beyond loop limit");

endmodule

>>> hdl/exp2x_taylor_series.sv
// ----------------------------------------------------------------------------
// exp2x_taylor_series
// e^(2x) by Taylor series in fixed point: a truncated sum over a configured
// number of terms and a reference sum, both Q4.24, from one pass of terms.
// ----------------------------------------------------------------------------
// A request (x in Q1.16) is taken when start is high and busy is low. An
// argument outside 0.1..1.0 is answered on the next cycle with range_error
// set and both sums zero. Otherwise the block builds max(num_terms, 24)
// terms, each through the shared multiplier, the four-bit-per-cycle
// divider by k and an accumulate step. The response strobe comes in the
// cycle after the last accumulate, and busy drops in that same cycle. The
// response is shown for one cycle only and cannot be held off: capture it
// when rsp_strobe is high.
// Write num_terms only while busy is low and no response is pending.
// ----------------------------------------------------------------------------
module exp2x_taylor_series (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [exp2x_pkg::X_W-1:0]      req_x_value,
   output logic                           rsp_strobe,
   output logic [exp2x_pkg::OUT_W-1:0]    rsp_series_sum,
   output logic [exp2x_pkg::OUT_W-1:0]    rsp_reference_sum,
   output logic                           rsp_range_error,
   input  logic                           csr_wr_en,
   input  logic [exp2x_pkg::CNT_W-1:0]    csr_wr_data
);

   exp2x_pkg::ctrl_cmd_type  cmd;
   exp2x_pkg::dp_status_type status;

   // Sequencer
   exp2x_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Term datapath
   exp2x_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_x_value       (req_x_value),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_series_sum    (rsp_series_sum),
      .rsp_reference_sum (rsp_reference_sum),
      .rsp_range_error   (rsp_range_error)
   );

endmodule
